/* rtl/nmea_gga_pkg.sv */
package nmea_gga_pkg;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;

    // Field indexes within the sentence
    localparam logic [3:0] FIELD_ID  = 4'd0;
    localparam logic [3:0] FIELD_LAT = 4'd2;
    localparam logic [3:0] FIELD_LON = 4'd4;
    localparam logic [3:0] FIELD_ALT = 4'd9;

    // Minimum field lengths in characters
    localparam logic [3:0] ID_MIN_LEN  = 4'd5;
    localparam logic [3:0] LAT_MIN_LEN = 4'd10;
    localparam logic [3:0] LON_MIN_LEN = 4'd11;

    localparam int LAT_W = 30;
    localparam int LON_W = 34;
    localparam int MIN_W = 24;
    localparam int E7_W  = 27;

    typedef struct packed {
        logic       clear;
        logic       lat_deg_en;
        logic       lat_min_en;
        logic       lon_deg_en;
        logic       lon_min_en;
        logic [3:0] digit;
        logic       emit;
        logic       digits_ok;
    } nmea_gga_ctrl_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    // One decimal digit scaled to degrees times 10^7
    function automatic logic [E7_W-1:0] digit_e7(input logic [3:0] d);
        return E7_W'(d) * E7_W'(10000000);
    endfunction

endpackage

/* rtl/nmea_gga_position_parser.sv */
// Channel | Direction | Ports                                   | Payload
// s_      | in        | s_valid, s_ready                        | s_rx_byte
// m_      | out       | m_valid, m_ready                        | m_latitude_e7, m_longitude_e7,
//         |           |                                         | m_digits_ok
//
// One byte per cycle sustained while the result is not stalled; a result becomes
// valid once the comma that closes the altitude field has passed the input
// register, then the parse and accumulate step into the result register.
// Synchronous active-low reset clears the handshake and parser state only.
// A stalled result holds the input register; s_ready drops only when both
// the input register and the result register are full and m_ready is low.
module nmea_gga_position_parser
    import nmea_gga_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_rx_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [LAT_W-1:0] m_latitude_e7,
    output logic [LON_W-1:0] m_longitude_e7,
    output logic             m_digits_ok
);

    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             m_valid_reg;
    logic [LAT_W-1:0] lat_reg;
    logic [LON_W-1:0] lon_reg;
    logic             ok_reg;
    logic             out_free;
    logic             step;
    nmea_gga_ctrl_t   ctrl;
    logic [LAT_W-1:0] lat_value;
    logic [LON_W-1:0] lon_value;

    assign out_free = !m_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    nmea_gga_field_track u_track (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_i  (step),
        .byte_i  (in_byte_reg),
        .ctrl_o  (ctrl)
    );

    nmea_gga_coord_acc #(
        .OUT_W (LAT_W)
    ) u_lat (
        .aclk     (aclk),
        .clear_i  (ctrl.clear),
        .deg_en_i (ctrl.lat_deg_en),
        .min_en_i (ctrl.lat_min_en),
        .digit_i  (ctrl.digit),
        .value_o  (lat_value)
    );

    nmea_gga_coord_acc #(
        .OUT_W (LON_W)
    ) u_lon (
        .aclk     (aclk),
        .clear_i  (ctrl.clear),
        .deg_en_i (ctrl.lon_deg_en),
        .min_en_i (ctrl.lon_min_en),
        .digit_i  (ctrl.digit),
        .value_o  (lon_value)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.emit) begin
            lat_reg <= lat_value;
            lon_reg <= lon_value;
            ok_reg  <= ctrl.digits_ok;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_latitude_e7  = lat_reg;
    assign m_longitude_e7 = lon_reg;
    assign m_digits_ok    = ok_reg;

`ifndef SYNTHESIS
    a_emit_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit |-> step)
        else $error("result produced without an item in the parse stage");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(in_byte_reg))
        else $error("input register lost its item under a stall");

    a_dollar_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        step && in_byte_reg == CH_DOLLAR |=> lat_value == '0 && lon_value == '0)
        else $error("accumulators not cleared at start of sentence");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg && $stable(lat_reg)
            && $stable(lon_reg) && $stable(ok_reg))
        else $error("new result overwrote a result still waiting");
`endif

endmodule

/* rtl/nmea_gga_field_track.sv */
module nmea_gga_field_track
    import nmea_gga_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step_i,
    input  logic [7:0]     byte_i,
    output nmea_gga_ctrl_t ctrl_o
);

    logic       in_sentence_reg, in_sentence_next;
    logic       is_gga_reg,      is_gga_next;
    logic [3:0] field_reg,       field_next;
    logic [3:0] pos_reg,         pos_next;
    logic       fault_reg,       fault_next;
    logic       byte_is_digit;
    logic       digit_en;

    always_comb begin
        in_sentence_next = in_sentence_reg;
        is_gga_next      = is_gga_reg;
        field_next       = field_reg;
        pos_next         = pos_reg;
        fault_next       = fault_reg;
        byte_is_digit    = is_digit(byte_i);
        ctrl_o           = '0;
        ctrl_o.digit     = byte_is_digit ? byte_i[3:0] : 4'd0;
        ctrl_o.digits_ok = !fault_reg;
        digit_en         = 1'b0;

        if (step_i) begin
            if (byte_i == CH_DOLLAR) begin
                // restart: drop any partial sentence
                ctrl_o.clear     = 1'b1;
                in_sentence_next = 1'b1;
                is_gga_next      = 1'b1;
                field_next       = FIELD_ID;
                pos_next         = '0;
                fault_next       = 1'b0;
            end else if (in_sentence_reg) begin
                if (byte_i == CH_COMMA) begin
                    field_next = field_reg + 4'd1;
                    pos_next   = '0;
                    unique case (field_reg)
                        FIELD_ID: begin
                            if (!(is_gga_reg && pos_reg >= ID_MIN_LEN)) begin
                                in_sentence_next = 1'b0;
                                field_next       = field_reg;
                                pos_next         = pos_reg;
                            end
                        end
                        FIELD_LAT: begin
                            if (pos_reg < LAT_MIN_LEN) fault_next = 1'b1;
                        end
                        FIELD_LON: begin
                            if (pos_reg < LON_MIN_LEN) fault_next = 1'b1;
                        end
                        FIELD_ALT: begin
                            ctrl_o.emit      = 1'b1;
                            in_sentence_next = 1'b0;
                            field_next       = field_reg;
                            pos_next         = pos_reg;
                        end
                        default: ;
                    endcase
                end else begin
                    unique case (field_reg)
                        FIELD_ID: begin
                            if ((pos_reg == 4'd2 || pos_reg == 4'd3) && byte_i != CH_G)
                                is_gga_next = 1'b0;
                            if (pos_reg == 4'd4 && byte_i != CH_A)
                                is_gga_next = 1'b0;
                        end
                        FIELD_LAT: begin
                            // ddmm.mmmmm, decimal point unchecked
                            if (pos_reg <= 4'd1)
                                ctrl_o.lat_deg_en = 1'b1;
                            else if (pos_reg <= 4'd3 || (pos_reg >= 4'd5 && pos_reg <= 4'd9))
                                ctrl_o.lat_min_en = 1'b1;
                        end
                        FIELD_LON: begin
                            // dddmm.mmmmm
                            if (pos_reg <= 4'd2)
                                ctrl_o.lon_deg_en = 1'b1;
                            else if (pos_reg <= 4'd4 || (pos_reg >= 4'd6 && pos_reg <= 4'd10))
                                ctrl_o.lon_min_en = 1'b1;
                        end
                        default: ;
                    endcase
                    digit_en = ctrl_o.lat_deg_en | ctrl_o.lat_min_en
                             | ctrl_o.lon_deg_en | ctrl_o.lon_min_en;
                    if (digit_en && !byte_is_digit) fault_next = 1'b1;
                    if (pos_reg != 4'hF) pos_next = pos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sentence_reg <= 1'b0;
            is_gga_reg      <= 1'b0;
            field_reg       <= '0;
            pos_reg         <= '0;
            fault_reg       <= 1'b0;
        end else begin
            in_sentence_reg <= in_sentence_next;
            is_gga_reg      <= is_gga_next;
            field_reg       <= field_next;
            pos_reg         <= pos_next;
            fault_reg       <= fault_next;
        end
    end

endmodule

/* rtl/nmea_gga_coord_acc.sv */
module nmea_gga_coord_acc
    import nmea_gga_pkg::*;
#(
    parameter int OUT_W = LAT_W
) (
    input  logic             aclk,
    input  logic             clear_i,
    input  logic             deg_en_i,
    input  logic             min_en_i,
    input  logic [3:0]       digit_i,
    output logic [OUT_W-1:0] value_o
);

    // Degrees are kept already scaled by 10^7. Minutes are kept as the running
    // quotient and remainder of 5*m/3, so m*100/60 needs no divider.
    logic [OUT_W-1:0] deg_e7_reg, deg_e7_next;
    logic [MIN_W-1:0] quot_reg,   quot_next;
    logic [1:0]       rem_reg,    rem_next;
    logic [6:0]       part;
    logic [4:0]       part_q;
    logic [11:0]      part_scaled;

    always_comb begin
        deg_e7_next = deg_e7_reg;
        quot_next   = quot_reg;
        rem_next    = rem_reg;
        // part = 10*r + 5*d stays below 66, so (part*43)>>7 is exact part/3
        part        = 7'(rem_reg) * 7'd10 + 7'(digit_i) * 7'd5;
        part_scaled = 12'(part) * 12'd43;
        part_q      = part_scaled[11:7];
        if (clear_i) begin
            deg_e7_next = '0;
            quot_next   = '0;
            rem_next    = '0;
        end else if (deg_en_i) begin
            deg_e7_next = (deg_e7_reg << 3) + (deg_e7_reg << 1) + OUT_W'(digit_e7(digit_i));
        end else if (min_en_i) begin
            quot_next = (quot_reg << 3) + (quot_reg << 1) + MIN_W'(part_q);
            rem_next  = 2'(part - 7'(part_q) * 7'd3);
        end
    end

    always_ff @(posedge aclk) begin
        deg_e7_reg <= deg_e7_next;
        quot_reg   <= quot_next;
        rem_reg    <= rem_next;
    end

    assign value_o = deg_e7_reg + OUT_W'(quot_reg);

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import nmea_gga_pkg::*;

    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_UPPER  = 8'h41;
    localparam int LAT_POINT_POS     = 4;
    localparam int LON_POINT_POS     = 5;
    localparam int POS_MAX           = 15;
    localparam int GAP_MAX           = 18;
    localparam int RANDOM_BYTES      = 250;
    localparam int RANDOM_FIXES      = 4;
    localparam int SETTLE_CYCLES     = 8;
    localparam int LONG_HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
        logic             ok;
    } gga_fix_t;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    logic [7:0]       s_rx_byte = 8'h00;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    logic [LAT_W-1:0] m_latitude_e7;
    logic [LON_W-1:0] m_longitude_e7;
    logic             m_digits_ok;

    // Expected fixes, oldest first
    gga_fix_t fix_queue[$];

    // Tracked parser state
    bit         trk_in_sentence = 1'b0;
    bit         trk_id_match    = 1'b0;
    bit         trk_fault       = 1'b0;
    logic [3:0] trk_field       = '0;
    logic [3:0] trk_pos         = '0;
    logic [6:0] trk_lat_deg     = '0;
    logic [23:0] trk_lat_min    = '0;
    logic [9:0] trk_lon_deg     = '0;
    logic [23:0] trk_lon_min    = '0;

    int error_count     = 0;
    int parsed_bytes    = 0;
    int fixes_predicted = 0;
    int src_gap_max     = 0;
    int sink_stall_max  = 0;
    int sink_hold_req   = 0;

    nmea_gga_position_parser dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_latitude_e7  (m_latitude_e7),
        .m_longitude_e7 (m_longitude_e7),
        .m_digits_ok    (m_digits_ok)
    );

    always #5 aclk = ~aclk;

    function automatic logic [3:0] digit_of(input logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE) begin
            return 4'(b - CH_ZERO);
        end
        trk_fault = 1'b1;
        return 4'd0;
    endfunction

    task automatic track_byte(input logic [7:0] b);
        logic [63:0] lat_full;
        logic [63:0] lon_full;
        gga_fix_t    fx;
        if (b == CH_DOLLAR || trk_in_sentence) begin
            parsed_bytes++;
        end
        if (b == CH_DOLLAR) begin
            trk_in_sentence = 1'b1;
            trk_id_match    = 1'b1;
            trk_fault       = 1'b0;
            trk_field       = '0;
            trk_pos         = '0;
            trk_lat_deg     = '0;
            trk_lat_min     = '0;
            trk_lon_deg     = '0;
            trk_lon_min     = '0;
            return;
        end
        if (!trk_in_sentence) begin
            return;
        end
        if (b == CH_COMMA) begin
            case (trk_field)
                FIELD_ID: begin
                    if (!(trk_id_match && trk_pos >= ID_MIN_LEN)) begin
                        trk_in_sentence = 1'b0;
                        return;
                    end
                end
                FIELD_LAT: begin
                    if (trk_pos < LAT_MIN_LEN) trk_fault = 1'b1;
                end
                FIELD_LON: begin
                    if (trk_pos < LON_MIN_LEN) trk_fault = 1'b1;
                end
                FIELD_ALT: begin
                    lat_full = 64'(trk_lat_deg) * 64'd10000000
                             + (64'(trk_lat_min) * 64'd100) / 64'd60;
                    lon_full = 64'(trk_lon_deg) * 64'd10000000
                             + (64'(trk_lon_min) * 64'd100) / 64'd60;
                    fx.lat = lat_full[LAT_W-1:0];
                    fx.lon = lon_full[LON_W-1:0];
                    fx.ok  = !trk_fault;
                    fix_queue.push_back(fx);
                    fixes_predicted++;
                    trk_in_sentence = 1'b0;
                    return;
                end
                default: ;
            endcase
            trk_field = trk_field + 4'd1;
            trk_pos   = '0;
            return;
        end
        case (trk_field)
            FIELD_ID: begin
                if (trk_pos == 2 || trk_pos == 3) begin
                    if (b != CH_G) trk_id_match = 1'b0;
                end else if (trk_pos == 4) begin
                    if (b != CH_A) trk_id_match = 1'b0;
                end
            end
            FIELD_LAT: begin
                if (trk_pos <= 1) begin
                    trk_lat_deg = 7'(trk_lat_deg * 10 + digit_of(b));
                end else if (trk_pos < LAT_MIN_LEN && trk_pos != LAT_POINT_POS) begin
                    trk_lat_min = 24'(trk_lat_min * 10 + digit_of(b));
                end
            end
            FIELD_LON: begin
                if (trk_pos <= 2) begin
                    trk_lon_deg = 10'(trk_lon_deg * 10 + digit_of(b));
                end else if (trk_pos < LON_MIN_LEN && trk_pos != LON_POINT_POS) begin
                    trk_lon_min = 24'(trk_lon_min * 10 + digit_of(b));
                end
            end
            default: ;
        endcase
        if (trk_pos != POS_MAX) trk_pos = trk_pos + 4'd1;
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = $urandom_range(src_gap_max, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        track_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_byte(s[i]);
        end
    endtask

    function automatic logic [7:0] rand_text_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(255, 0)); while (b == CH_COMMA || b == CH_DOLLAR);
        return b;
    endfunction

    // Loose filler may carry stray commas, which shift the field count
    task automatic send_filler(input int len, input bit loose);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = rand_text_byte();
            if (loose && $urandom_range(7, 0) == 0) b = CH_COMMA;
            send_byte(b);
        end
    endtask

    task automatic send_coord(input int len, input int point_at, input int bad_pct);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            if (i == point_at) begin
                c = ($urandom_range(9, 0) == 0) ? rand_text_byte() : CH_POINT;
            end else begin
                c = CH_ZERO + 8'($urandom_range(9, 0));
            end
            if ($urandom_range(99, 0) < bad_pct) c = rand_text_byte();
            send_byte(c);
        end
    endtask

    function automatic int pick_len(input int nominal);
        int r;
        r = $urandom_range(9, 0);
        if (r < 8) return nominal;
        if (r == 8) return $urandom_range(nominal - 1, 0);
        return $urandom_range(nominal + 9, nominal + 1);
    endfunction

    function automatic int pick_gap_max();
        case ($urandom_range(3, 0))
            0:       return 0;
            1:       return 3;
            default: return GAP_MAX;
        endcase
    endfunction

    // Lower valid, then hold until every expected fix has been taken
    task automatic wait_fixes_drained();
        s_valid <= 1'b0;
        while (fix_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic check_fix();
        gga_fix_t want;
        if (fix_queue.size() == 0) begin
            $error("unexpected result: latitude_e7 %0d longitude_e7 %0d digits_ok %0d",
                   m_latitude_e7, m_longitude_e7, m_digits_ok);
            error_count++;
            return;
        end
        want = fix_queue.pop_front();
        if (m_latitude_e7 !== want.lat) begin
            $error("latitude_e7 expected %0d actual %0d", want.lat, m_latitude_e7);
            error_count++;
        end
        if (m_longitude_e7 !== want.lon) begin
            $error("longitude_e7 expected %0d actual %0d", want.lon, m_longitude_e7);
            error_count++;
        end
        if (m_digits_ok !== want.ok) begin
            $error("digits_ok expected %0d actual %0d", want.ok, m_digits_ok);
            error_count++;
        end
    endtask

    initial begin : result_sink
        int stall;
        forever begin
            if (sink_hold_req > 0) begin
                m_ready <= 1'b0;
                for (int n = 0; n < sink_hold_req; n++) @(posedge aclk);
                sink_hold_req = 0;
            end
            stall = $urandom_range(sink_stall_max, 0);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            check_fix();
        end
    end

    task automatic test_noise_before_dollar();
        src_gap_max    = GAP_MAX;
        sink_stall_max = GAP_MAX;
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(CH_COMMA);
        send_text("GPGGA,,4807.03812,,01131.00045,,,,,,");
        send_text("$GPGGA,123519,4807.03812,N,01131.00045,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
        wait_fixes_drained();
    endtask

    task automatic test_extreme_positions();
        src_gap_max    = 0;
        sink_stall_max = 0;
        send_text("$GPGGA,,9959.99999,,99959.99999,,,,,,");
        send_text("$GNGGA,,0000.00000,,00000.00000,,,,,,");
        send_text("$GPGGA,,9000.00000,,18000.00000,,,,,,");
        wait_fixes_drained();
    endtask

    task automatic test_identifier_checks();
        src_gap_max    = 3;
        sink_stall_max = GAP_MAX;
        // short identifiers, then wrong letters: all dropped
        send_text("$GGA,,4807.03812,,01131.00045,,,,,,");
        send_text("$G,,4807.03812,,01131.00045,,,,,,");
        send_text("$,,4807.03812,,01131.00045,,,,,,");
        send_text("$GPGSA,,4807.03812,,01131.00045,,,,,,");
        send_text("$GPGGB,,4807.03812,,01131.00045,,,,,,");
        send_text("$GPgGA,,4807.03812,,01131.00045,,,,,,");
        // overlong identifier still matches
        send_text("$XYGGAEXTRACHARACTERS,,1234.56789,,12345.67891,,,,,,");
        wait_fixes_drained();
    endtask

    task automatic test_dollar_restart();
        src_gap_max    = GAP_MAX;
        sink_stall_max = 3;
        send_text("$GPGGA,,1234.5");
        send_text("$GPGGA,,0102.03040,,00506.07080,,,,,12");
        send_text("$GPGGA,,1122.33445,,06677.88990,,,,,,");
        wait_fixes_drained();
    endtask

    task automatic test_bad_digits();
        src_gap_max    = 0;
        sink_stall_max = GAP_MAX;
        send_text("$GPGGA,,48A7.03812,,01131.0004Z,,,,,,");
        send_text("$GPGGA,,48/7.03812,,01131.00045,,,,,,");
        send_text("$GPGGA,,4807.03812,,011:1.00045,,,,,,");
        send_text("$GPGGA,,4807.038,,01131.00045,,,,,,");
        send_text("$GPGGA,,4807.03812,,01131.0,,,,,,");
        send_text("$GPGGA,,,,,,,,,,");
        // the decimal point character is not checked
        send_text("$GPGGA,,4807X03812,,01131Y00045,,,,,,");
        send_text("$GPGGA,,48");
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text(".03812,,0113");
        send_byte(8'h00);
        send_text(".00045,,,,,,");
        wait_fixes_drained();
    endtask

    task automatic test_overlong_fields();
        src_gap_max    = 3;
        sink_stall_max = 0;
        send_text("$GPGGA,,4807.038129999,,01131.000459999,,,,,,");
        send_text("$GPGGA,12345678901234567890,4807.03812345678901234,N,");
        send_text("01131.00045678901234567,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n");
        wait_fixes_drained();
    endtask

    task automatic test_backpressure();
        src_gap_max    = 0;
        sink_stall_max = 0;
        sink_hold_req  = LONG_HOLD_CYCLES;
        // the first fix starts the hold; the rest must back up into the input
        for (int k = 0; k < 4; k++) begin
            send_text("$GPGGA,,3749.12345,,12225.67890,,,,,,");
        end
        wait_fixes_drained();
    endtask

    task automatic send_random_sentence();
        bit loose;
        int bad_pct;
        int restart_at;
        int n_id;
        logic [7:0] id_chars[3];
        src_gap_max    = pick_gap_max();
        sink_stall_max = pick_gap_max();
        loose      = ($urandom_range(29, 0) == 0);
        bad_pct    = ($urandom_range(99, 0) < 85) ? 0 : 10;
        restart_at = ($urandom_range(24, 0) == 0) ? $urandom_range(9, 0) : -1;
        id_chars   = '{CH_G, CH_G, CH_A};
        if ($urandom_range(3, 0) == 0) begin
            send_filler($urandom_range(6, 1), 1'b0);
        end
        send_byte(CH_DOLLAR);
        for (int i = 0; i < 2; i++) begin
            if ($urandom_range(19, 0) == 0) send_byte(rand_text_byte());
            else send_byte(CH_UPPER + 8'($urandom_range(25, 0)));
        end
        n_id = ($urandom_range(24, 0) == 0) ? $urandom_range(2, 0) : 3;
        for (int i = 0; i < n_id; i++) begin
            if ($urandom_range(11, 0) == 0) send_byte(rand_text_byte());
            else send_byte(id_chars[i]);
        end
        if ($urandom_range(9, 0) == 0) send_filler($urandom_range(12, 1), 1'b0);
        send_byte(CH_COMMA);
        for (int f = 1; f <= int'(FIELD_ALT); f++) begin
            if (f == restart_at) send_byte(CH_DOLLAR);
            if (f == int'(FIELD_LAT)) begin
                send_coord(pick_len(int'(LAT_MIN_LEN)), LAT_POINT_POS, bad_pct);
            end else if (f == int'(FIELD_LON)) begin
                send_coord(pick_len(int'(LON_MIN_LEN)), LON_POINT_POS, bad_pct);
            end else begin
                send_filler($urandom_range(6, 0), loose);
            end
            send_byte(CH_COMMA);
        end
        send_filler($urandom_range(10, 0), 1'b0);
    endtask

    task automatic test_random_stream();
        int start_bytes;
        int start_fixes;
        start_bytes = parsed_bytes;
        start_fixes = fixes_predicted;
        while (parsed_bytes - start_bytes < RANDOM_BYTES
               || fixes_predicted - start_fixes < RANDOM_FIXES) begin
            send_random_sentence();
            if ($urandom_range(29, 0) == 0) wait_fixes_drained();
        end
        wait_fixes_drained();
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_noise_before_dollar();
        test_extreme_positions();
        test_identifier_checks();
        test_dollar_restart();
        test_bad_digits();
        test_overlong_fields();
        test_backpressure();
        test_random_stream();
        if (fix_queue.size() != 0) begin
            $error("%0d expected results never arrived", fix_queue.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin : watchdog
        #8_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* nmea_gga_position_parser.f */
rtl/nmea_gga_pkg.sv
rtl/nmea_gga_field_track.sv
rtl/nmea_gga_coord_acc.sv
rtl/nmea_gga_position_parser.sv
tb/sv/tb_top.sv
